>>> design/rud_pkg.sv
`default_nettype none

package rud_pkg;

    // Width of every operand and result field on the ports.
    localparam int FIELD_W = 16;

endpackage

`default_nettype wire

>>> design/restoring_unsigned_divider_top.sv
`default_nettype none

// Channel   | Ports                                   | Direction
// ----------+-----------------------------------------+----------
// operands  | s_valid s_ready s_dividend s_divisor    | in
// results   | m_valid m_ready m_quotient m_remainder  | out
//
// Cycles: one division per clock while m_ready is high; one
//   pipeline stage per dividend bit, each holding one WIDTH+2 bit subtract.
// Reset: aresetn is synchronous, active low, and empties every stage.
// Stalls: each stage moves on when the next one is empty or moving, so
//   bubbles close up and new operands keep entering while a result waits.
//   s_ready is low only when every stage holds an item and m_ready is low.
// Divisor zero returns an all-ones quotient and the dividend as remainder.
module restoring_unsigned_divider_top #(
    parameter int WIDTH = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [rud_pkg::FIELD_W-1:0]  s_dividend,
    input  wire logic [rud_pkg::FIELD_W-1:0]  s_divisor,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rud_pkg::FIELD_W-1:0]       m_quotient,
    output logic [rud_pkg::FIELD_W-1:0]       m_remainder
);

    import rud_pkg::*;

    // Stage boundaries: index 0 is the input, index WIDTH the output.
    logic [WIDTH:0]   valid_w;
    logic [WIDTH:0]   ready_w;
    logic [WIDTH-1:0] rem_w [0:WIDTH];
    logic [WIDTH-1:0] dq_w  [0:WIDTH];
    logic [WIDTH-1:0] div_w [0:WIDTH];

    // Fit the port fields to the internal width: drop or zero-fill top bits.
    generate
        if (WIDTH <= FIELD_W) begin : g_in_narrow
            assign dq_w[0]  = s_dividend[WIDTH-1:0];
            assign div_w[0] = s_divisor[WIDTH-1:0];
        end else begin : g_in_wide
            assign dq_w[0]  = {{(WIDTH-FIELD_W){1'b0}}, s_dividend};
            assign div_w[0] = {{(WIDTH-FIELD_W){1'b0}}, s_divisor};
        end
    endgenerate

    // The partial remainder starts at zero for every transfer.
    assign rem_w[0]   = '0;
    assign valid_w[0] = s_valid;
    assign s_ready    = ready_w[0];

    genvar gi;
    generate
        for (gi = 0; gi < WIDTH; gi++) begin : g_stage
            rud_stage #(
                .WIDTH (WIDTH)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (valid_w[gi]),
                .in_ready  (ready_w[gi]),
                .in_rem    (rem_w[gi]),
                .in_dq     (dq_w[gi]),
                .in_div    (div_w[gi]),
                .out_valid (valid_w[gi+1]),
                .out_ready (ready_w[gi+1]),
                .out_rem   (rem_w[gi+1]),
                .out_dq    (dq_w[gi+1]),
                .out_div   (div_w[gi+1])
            );
        end
    endgenerate

    // The last stage register is the output register.
    assign ready_w[WIDTH] = m_ready;
    assign m_valid        = valid_w[WIDTH];

    // After the last step dq holds only quotient bits; fit them to the port.
    generate
        if (WIDTH <= FIELD_W) begin : g_out_narrow
            assign m_quotient  = FIELD_W'(dq_w[WIDTH]);
            assign m_remainder = FIELD_W'(rem_w[WIDTH]);
        end else begin : g_out_wide
            assign m_quotient  = dq_w[WIDTH][FIELD_W-1:0];
            assign m_remainder = rem_w[WIDTH][FIELD_W-1:0];
        end
    endgenerate

`ifndef NO_ASSERTIONS
    // A finished division leaves a remainder below any nonzero divisor.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_w[WIDTH] && (div_w[WIDTH] != '0)) |-> (rem_w[WIDTH] < div_w[WIDTH]))
        else $error("remainder not below divisor");

    // Divisor zero yields an all-ones quotient.
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_w[WIDTH] && (div_w[WIDTH] == '0)) |-> (&dq_w[WIDTH]))
        else $error("zero divisor without all-ones quotient");

    // Bubbles close up: operands are refused only when every stage is full.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_w[WIDTH:1]))
        else $error("operand transfer refused with an empty stage");
`endif

endmodule

`default_nettype wire

>>> design/rud_stage.sv
`default_nettype none

// One restoring step: shift the partial remainder left, take in the next
// dividend bit, subtract the divisor when it fits, and record the quotient bit.
// The dividend bits leave dq at the top while quotient bits enter at the bottom.
module rud_stage #(
    parameter int WIDTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_rem,
    input  wire logic [WIDTH-1:0] in_dq,
    input  wire logic [WIDTH-1:0] in_div,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_rem,
    output logic [WIDTH-1:0]      out_dq,
    output logic [WIDTH-1:0]      out_div
);

    logic             valid_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] dq_reg;
    logic [WIDTH-1:0] div_reg;

    logic [WIDTH+1:0] shifted;
    logic [WIDTH+1:0] trial;
    logic             fits;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] dq_next;

    // Shifted remainder keeps the bit pushed out at the top; the extra
    // top bit of the trial difference is the borrow.
    assign shifted  = {1'b0, in_rem, in_dq[WIDTH-1]};
    assign trial    = shifted - {2'b00, in_div};
    assign fits     = ~trial[WIDTH+1];
    assign rem_next = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
    assign dq_next  = {in_dq[WIDTH-2:0], fits};

    // Take a new item whenever this slot is empty or its item moves on.
    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            div_reg <= in_div;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_div   = div_reg;

endmodule

`default_nettype wire
